FILE: sv/ppmfd_pkg.sv
package ppmfd_pkg;

  // Field widths of the stream payloads and the configuration port.
  localparam int StampW   = 16;
  localparam int ChanSelW = 3;
  localparam int ValueW   = 15;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 24;
  localparam int OutDataW = 16;

  // Register values after reset.
  localparam logic [StampW-1:0] WrapPeriodReset    = 16'd40000;
  localparam logic [StampW-1:0] SyncThresholdReset = 16'd8000;
  localparam logic [ValueW-1:0] ClampLowReset      = 15'd1000;
  localparam logic [ValueW-1:0] ClampHighReset     = 15'd2000;
  localparam logic [StampW-1:0] SlotResetValue     = 16'd2400;

  typedef enum logic {
    CMD_CAPTURE = 1'b0,
    CMD_READ    = 1'b1
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_WRAP_PERIOD    = 2'd0,
    REG_SYNC_THRESHOLD = 2'd1,
    REG_CLAMP_LOW      = 2'd2,
    REG_CLAMP_HIGH     = 2'd3
  } reg_idx_e;

  // Write request into the channel slot store.
  typedef struct packed {
    logic              en;
    logic [StampW-1:0] data;
  } slot_wr_t;

endpackage

FILE: sv/ppm_frame_decoder.sv
// A result passes through the input register and then the result register before it is offered.
// Throughput: one item per cycle while the output is not stalled, set by the single subtract, compare and slot write.
// The input register keeps taking one item while a result waits on a stalled output.
// Reset is asynchronous and active low: registers return to their defaults, all slots
// hold 2400, the slot index, last timestamp and ready flag clear, both stages empty.
module ppm_frame_decoder
  import ppmfd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [15:0] timestamp, [18:16] channel, [23:19] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] command
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [14:0] channel_value, [15] frame_ready
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  localparam int IdxW = $clog2(CHANNELS + 1);

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
  logic [StampW-1:0] wrap_q, sync_q;
  logic [ValueW-1:0] clamp_low_q, clamp_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q       <= WrapPeriodReset;
      sync_q       <= SyncThresholdReset;
      clamp_low_q  <= ClampLowReset;
      clamp_high_q <= ClampHighReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_addr_i))
        REG_WRAP_PERIOD:    wrap_q       <= cfg_wdata_i;
        REG_SYNC_THRESHOLD: sync_q       <= cfg_wdata_i;
        REG_CLAMP_LOW:      clamp_low_q  <= cfg_wdata_i[ValueW-1:0];
        REG_CLAMP_HIGH:     clamp_high_q <= cfg_wdata_i[ValueW-1:0];
      endcase
    end
  end

  // Input register stage. It drains whenever the result register can load, so a
  // new transaction is taken in the same cycle that the previous item moves on.
  logic               item_valid_q, item_valid_d;
  cmd_e               item_cmd_q;
  logic [StampW-1:0]  item_stamp_q;
  logic [ChanSelW-1:0] item_chan_q;
  logic               in_accept, out_load;
  logic               out_valid_q, out_valid_d;

  assign out_load        = item_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !item_valid_q || out_load;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (out_load) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_cmd_q   <= cmd_e'(s_axis_tuser_i);
      item_stamp_q <= s_axis_tdata_i[StampW-1:0];
      item_chan_q  <= s_axis_tdata_i[StampW +: ChanSelW];
    end
  end

  // Decoder state. It advances when an item moves into the result register.
  logic [StampW-1:0] last_stamp_q, last_stamp_d;
  logic [IdxW-1:0]   slot_idx_q, slot_idx_d;
  logic              ready_q, ready_d;

  logic [StampW-1:0] interval;
  logic              is_sync, slot_room, do_capture, do_read;
  slot_wr_t          slot_wr;
  logic [ValueW-1:0] rd_value;

  // Interval to the previous edge. When the timer has wrapped, one period is added;
  // the sum is kept modulo 2^16 like the timer itself.
  assign interval   = item_stamp_q - last_stamp_q
                      + ((item_stamp_q < last_stamp_q) ? wrap_q : '0);
  assign is_sync    = interval > sync_q;
  assign slot_room  = slot_idx_q < IdxW'(CHANNELS);
  assign do_capture = out_load && (item_cmd_q == CMD_CAPTURE);
  assign do_read    = out_load && (item_cmd_q == CMD_READ);

  // Pulses that arrive after all slots are filled are dropped until the next sync.
  assign slot_wr.en   = do_capture && !is_sync && slot_room;
  assign slot_wr.data = interval;

  always_comb begin
    last_stamp_d = last_stamp_q;
    slot_idx_d   = slot_idx_q;
    ready_d      = ready_q;
    if (do_capture) begin
      last_stamp_d = item_stamp_q;
      if (is_sync) begin
        slot_idx_d = '0;
        ready_d    = 1'b1;
      end else if (slot_room) begin
        slot_idx_d = slot_idx_q + 1'b1;
        if (slot_idx_q == IdxW'(CHANNELS - 1)) begin
          ready_d = 1'b1;
        end
      end
    end else if (do_read) begin
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
      slot_idx_q   <= '0;
      ready_q      <= 1'b0;
    end else begin
      last_stamp_q <= last_stamp_d;
      slot_idx_q   <= slot_idx_d;
      ready_q      <= ready_d;
    end
  end

  ppmfd_slot_store #(
    .CHANNELS (CHANNELS)
  ) u_slot_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (slot_wr),
    .wr_idx_i     (slot_idx_q),
    .rd_chan_i    (item_chan_q),
    .clamp_low_i  (clamp_low_q),
    .clamp_high_i (clamp_high_q),
    .rd_value_o   (rd_value)
  );

  // Result register. The reported flag is the one that stood before the item.
  logic [ValueW-1:0] out_value_q;
  logic              out_flag_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= (item_cmd_q == CMD_READ) ? rd_value : '0;
      out_flag_q  <= ready_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_flag_q, out_value_q};

  // The slot index never runs past the channel count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_idx_q <= IdxW'(CHANNELS))
    else $error("slot index beyond channel count");

  // A read always leaves the ready flag clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_read |=> !ready_q)
    else $error("ready flag not cleared by read");

  // A capture result carries a zero channel value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_capture |=> (out_value_q == '0))
    else $error("capture result has nonzero value");

  // Filling the last slot raises the ready flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (slot_wr.en && slot_idx_q == IdxW'(CHANNELS - 1)) |=> ready_q)
    else $error("ready flag not set on last slot");

  // An empty input register always takes a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_valid_q |-> s_axis_tready_o)
    else $error("input stalled while input register empty");

endmodule

FILE: sv/ppmfd_slot_store.sv
module ppmfd_slot_store
  import ppmfd_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  slot_wr_t                        wr_i,
  input  logic [$clog2(CHANNELS+1)-1:0]   wr_idx_i,
  input  logic [ChanSelW-1:0]             rd_chan_i,
  input  logic [ValueW-1:0]               clamp_low_i,
  input  logic [ValueW-1:0]               clamp_high_i,
  output logic [ValueW-1:0]               rd_value_o
);

  localparam int IdxW = $clog2(CHANNELS + 1);
  localparam int CmpW = (ChanSelW > IdxW) ? ChanSelW : IdxW;

  logic [StampW-1:0] slots_q [CHANNELS];
  logic [StampW-1:0] raw;
  logic [ValueW-1:0] half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        slots_q[i] <= SlotResetValue;
      end
    end else if (wr_i.en) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (wr_idx_i == IdxW'(i)) begin
          slots_q[i] <= wr_i.data;
        end
      end
    end
  end

  // A channel outside the configured slots reads as zero.
  always_comb begin
    raw = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (CmpW'(rd_chan_i) == CmpW'(i)) begin
        raw = slots_q[i];
      end
    end
  end

  assign half = raw[StampW-1:1];

  // With inverted bounds, values below the low bound read as the low bound, all others as the high bound.
  always_comb begin
    priority if (half < clamp_low_i) begin
      rd_value_o = clamp_low_i;
    end else if (half > clamp_high_i) begin
      rd_value_o = clamp_high_i;
    end else begin
      rd_value_o = half;
    end
  end

endmodule

FILE: tb/ppm_frame_decoder_tb.sv
`timescale 1ns / 1ps

module ppm_frame_decoder_tb;
  import ppmfd_pkg::*;

  // Block configuration and timing of the bench.
  localparam int NumChannels  = 8;
  localparam int DutLatency   = 2;     // input register plus result register
  localparam int ResetCycles  = 12;
  localparam int HoldCycles   = 80;    // long receiver hold-off for the pressure test
  localparam int WatchdogMax  = 2000;  // cycles without any transaction before giving up

  // One expected result: the clamped channel value and the ready flag as it stood.
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              ready;
  } result_t;

  // Clock, reset and all block inputs start at known values.
  logic                clk_i    = 1'b0;
  logic                rst_ni   = 1'b0;
  logic                cfg_we   = 1'b0;
  reg_idx_e            cfg_addr = REG_WRAP_PERIOD;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_valid  = 1'b0;
  logic [InDataW-1:0]  s_data   = '0;
  cmd_e                s_cmd    = CMD_CAPTURE;
  logic                m_ready  = 1'b0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Decoder state as the bench expects it to be, updated at every accepted input.
  logic [StampW-1:0] prev_stamp;
  logic [3:0]        next_slot;
  logic [StampW-1:0] slot_val [NumChannels];
  logic              frame_flag;
  logic [StampW-1:0] cfg_wrap;
  logic [StampW-1:0] cfg_sync;
  logic [ValueW-1:0] cfg_lo;
  logic [ValueW-1:0] cfg_hi;

  result_t expected_q [$];

  // Run bookkeeping.
  int  errors     = 0;
  int  n_items    = 0;
  int  n_results  = 0;
  int  n_settings = 0;
  bit  idle_on    = 1'b1;
  bit  hold_req   = 1'b0;
  int  stall_left = 0;
  int  quiet_cycles = 0;

  ppm_frame_decoder #(
    .CHANNELS(NumChannels)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    // [15:0] timestamp, [18:16] channel, [23:19] zero
    .s_axis_tdata_i  (s_data),
    // [0] command
    .s_axis_tuser_i  (s_cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    // [14:0] channel_value, [15] frame_ready
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #4 clk_i = ~clk_i;

  // Puts the expected decoder state back to its power-on values.
  function automatic void reset_decoder_state();
    prev_stamp = '0;
    next_slot  = '0;
    frame_flag = 1'b0;
    cfg_wrap   = WrapPeriodReset;
    cfg_sync   = SyncThresholdReset;
    cfg_lo     = ClampLowReset;
    cfg_hi     = ClampHighReset;
    for (int i = 0; i < NumChannels; i++) slot_val[i] = SlotResetValue;
  endfunction

  // Works out the result of one accepted input transaction and advances the
  // expected state. A capture measures the pulse since the previous edge,
  // folding in the timer period when the counter has wrapped; a gap longer
  // than the sync threshold restarts the frame. A read halves and clamps.
  function automatic void decode_item(cmd_e cmd, logic [StampW-1:0] stamp,
                                      logic [ChanSelW-1:0] chan);
    result_t           res;
    logic [StampW-1:0] gap;
    logic [ValueW-1:0] half;
    res.ready = frame_flag;
    res.value = '0;
    if (cmd == CMD_CAPTURE) begin
      if (stamp < prev_stamp) begin
        gap = stamp + cfg_wrap - prev_stamp;
      end else begin
        gap = stamp - prev_stamp;
      end
      if (gap > cfg_sync) begin
        next_slot  = '0;
        frame_flag = 1'b1;
      end else if (next_slot < NumChannels) begin
        // Once every slot is full, further pulses are dropped until the next sync.
        slot_val[next_slot] = gap;
        next_slot++;
        if (next_slot >= NumChannels) frame_flag = 1'b1;
      end
      prev_stamp = stamp;
    end else begin
      half = (chan < NumChannels) ? slot_val[chan][StampW-1:1] : '0;
      // With inverted bounds, values below the low bound read as the low bound, all others as the high bound.
      if (half < cfg_lo) begin
        res.value = cfg_lo;
      end else if (half > cfg_hi) begin
        res.value = cfg_hi;
      end else begin
        res.value = half;
      end
      frame_flag = 1'b0;
    end
    expected_q.push_back(res);
  endfunction

  // Offers one input transaction, possibly after a short idle burst, and
  // records its expected result once the block has taken it. Valid stays
  // high on return so that the next item can follow without a bubble.
  task automatic send_item(input cmd_e cmd, input logic [StampW-1:0] stamp,
                           input logic [ChanSelW-1:0] chan);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_cmd   <= cmd;
    s_data  <= {5'b0, chan, stamp};
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_item(cmd, stamp, chan);
    n_items++;
  endtask

  // Sends a capture whose timestamp lies the given number of counts after
  // the previous edge, wrapping at the configured timer period.
  task automatic send_interval(input int counts);
    int nxt;
    nxt = int'(prev_stamp) + counts;
    if (nxt >= int'(cfg_wrap)) nxt -= int'(cfg_wrap);
    send_item(CMD_CAPTURE, nxt[StampW-1:0], ChanSelW'($urandom));
  endtask

  task automatic send_read(input logic [ChanSelW-1:0] chan);
    send_item(CMD_READ, StampW'($urandom), chan);
  endtask

  // Stops offering input and waits until every expected result has arrived.
  task automatic wait_idle();
    s_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DutLatency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      REG_WRAP_PERIOD:    cfg_wrap = val;
      REG_SYNC_THRESHOLD: cfg_sync = val;
      REG_CLAMP_LOW:      cfg_lo   = val[ValueW-1:0];
      REG_CLAMP_HIGH:     cfg_hi   = val[ValueW-1:0];
      default: ;
    endcase
  endtask

  // Registers change only with the block drained.
  task automatic apply_setting(input int wrap, input int thr, input int lo, input int hi);
    wait_idle();
    write_reg(REG_WRAP_PERIOD, CfgDataW'(wrap));
    write_reg(REG_SYNC_THRESHOLD, CfgDataW'(thr));
    write_reg(REG_CLAMP_LOW, CfgDataW'(lo));
    write_reg(REG_CLAMP_HIGH, CfgDataW'(hi));
    n_settings++;
  endtask

  task automatic pick_random_setting();
    int wrap;
    int thr;
    int lo;
    int hi;
    wrap = $urandom_range(20000, 65535);
    thr  = $urandom_range(2000, wrap / 3);
    lo   = $urandom_range(0, 1500);
    // About one setting in five has inverted clamp bounds.
    hi   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, lo) : $urandom_range(lo, 4000);
    apply_setting(wrap, thr, lo, hi);
  endtask

  // A channel pulse never exceeds the sync threshold; most look like servo pulses.
  function automatic int pulse_counts();
    if (cfg_sync >= 4400 && $urandom_range(0, 3) != 0) return $urandom_range(600, 4400);
    return $urandom_range(0, cfg_sync);
  endfunction

  function automatic int sync_counts();
    if (int'(cfg_sync) + 1 < int'(cfg_wrap)) return $urandom_range(int'(cfg_sync) + 1,
                                                                   int'(cfg_wrap) - 1);
    return $urandom_range(0, 65535);
  endfunction

  // Mostly whole frames (sync gap, a channel's worth of pulses, a few reads),
  // some short or overlong frames, and the rest stray captures and reads.
  task automatic run_traffic(input int count);
    int start;
    int pick;
    int pulses;
    start = n_items;
    while (n_items - start < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_interval(sync_counts());
        pulses = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NumChannels + 2)
                                              : NumChannels;
        repeat (pulses) send_interval(pulse_counts());
        repeat ($urandom_range(1, 4)) send_read(ChanSelW'($urandom));
      end else if (pick < 85) begin
        send_item(CMD_CAPTURE, StampW'($urandom), ChanSelW'($urandom));
      end else begin
        send_read(ChanSelW'($urandom));
      end
    end
  endtask

  // Reset values, sync detection, a pulse equal to the threshold, timer wrap,
  // a full frame, a dropped pulse once the slots are full, clamping at both
  // bounds, and the timestamp and channel extremes.
  task automatic test_directed();
    send_read(3'd0);
    send_read(3'd7);
    send_item(CMD_CAPTURE, 16'd9000, 3'd7);
    send_item(CMD_CAPTURE, 16'd17000, 3'd0);
    send_item(CMD_CAPTURE, 16'd39000, 3'd5);
    send_item(CMD_CAPTURE, 16'd500, 3'd2);
    send_interval(0);
    send_interval(1999);
    send_interval(2001);
    send_interval(4001);
    send_interval(4003);
    send_interval(3000);
    send_interval(1000);
    send_interval(1500);
    send_read(3'd0);
    send_read(3'd7);
    send_read(3'd4);
    send_item(CMD_CAPTURE, 16'hFFFF, 3'd7);
    send_item(CMD_CAPTURE, 16'h0000, 3'd0);
    send_item(CMD_CAPTURE, 16'h0000, 3'd3);
    send_read(3'd1);
    send_read(3'd2);
    send_read(3'd3);
    send_read(3'd5);
    send_read(3'd6);
  endtask

  // Register extremes: the shortest timer period with a zero threshold, the
  // longest period with a threshold nothing can exceed, the full clamp range,
  // and inverted clamp bounds.
  task automatic test_register_extremes();
    apply_setting(1, 0, 1000, 2000);
    repeat (16) begin
      if ($urandom_range(0, 2) == 0) begin
        send_read(ChanSelW'($urandom));
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(CMD_CAPTURE, prev_stamp, ChanSelW'($urandom));
      end else begin
        send_item(CMD_CAPTURE, StampW'($urandom), ChanSelW'($urandom));
      end
    end

    apply_setting(65535, 65535, 0, 32767);
    repeat (12) send_item(CMD_CAPTURE, StampW'($urandom), ChanSelW'($urandom));
    for (int ch = 0; ch < NumChannels; ch++) send_read(ChanSelW'(ch));

    apply_setting(65535, 40000, 32767, 0);
    send_interval(sync_counts());
    repeat (NumChannels) send_interval(pulse_counts());
    for (int ch = 0; ch < NumChannels; ch++) send_read(ChanSelW'(ch));

    apply_setting(40000, 8000, 1500, 1200);
    send_interval(sync_counts());
    repeat (NumChannels) send_interval($urandom_range(2000, 3600));
    for (int ch = 0; ch < NumChannels; ch++) send_read(ChanSelW'(ch));
  endtask

  task automatic test_random_frames();
    repeat (7) begin
      pick_random_setting();
      run_traffic(150);
    end
  endtask

  // The receiver holds off for a long stretch while frames keep coming, so
  // both pipeline stages fill and the block must stall its input.
  task automatic test_backpressure();
    apply_setting(40000, 8000, 1000, 2000);
    hold_req = 1'b1;
    run_traffic(40);
  endtask

  // Closing stretch with both sides running at full rate.
  task automatic test_full_rate();
    idle_on = 1'b0;
    pick_random_setting();
    run_traffic(100);
  endtask

  // Receiver: random stall bursts, one long hold-off on request, and no
  // stalls at all once idling is switched off.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HoldCycles - 1;
      m_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 5);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Every result transaction is matched against the oldest expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata_o);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata_o[ValueW-1:0] !== want.value) begin
          errors++;
          $display("%0t: channel_value mismatch, expected %0d, actual %0d", $time,
                   want.value, m_axis_tdata_o[ValueW-1:0]);
        end
        if (m_axis_tdata_o[ValueW] !== want.ready) begin
          errors++;
          $display("%0t: frame_ready mismatch, expected %0b, actual %0b", $time,
                   want.ready, m_axis_tdata_o[ValueW]);
        end
      end
    end
  end

  // A run that stops moving transactions for too long has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogMax) begin
        $display("%0t: no transaction for %0d cycles", $time, WatchdogMax);
        $display("ppm_frame_decoder_tb failed");
        $finish;
      end
    end
  end

  initial begin
    reset_decoder_state();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_extremes();
    test_random_frames();
    test_backpressure();
    test_full_rate();

    wait_idle();
    repeat (4 * DutLatency) @(posedge clk_i);
    $display("Decoded %0d input transactions into %0d checked results", n_items, n_results);
    $display("over %0d register settings, with stalls on both sides and a long hold-off.",
             n_settings);
    if (errors == 0) begin
      $display("ppm_frame_decoder_tb passed");
    end else begin
      $display("ppm_frame_decoder_tb failed");
    end
    $finish;
  end

endmodule

FILE: ppm_frame_decoder.f
sv/ppmfd_pkg.sv
sv/ppmfd_slot_store.sv
sv/ppm_frame_decoder.sv
tb/ppm_frame_decoder_tb.sv
